// ===== rtl/ils_pkg.sv =====
// Shared types, constants and state codes for the iterative linear solver.
package ils_pkg;

    localparam int MAX_SIZE   = 16;
    localparam int ROW_W      = $clog2(MAX_SIZE);
    localparam int COEFF_AW   = 2 * ROW_W;
    localparam int COEFF_DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int VEC_DEPTH  = 3 * MAX_SIZE;
    localparam int VEC_AW     = $clog2(VEC_DEPTH);
    localparam int CFG_IDX_W  = 3;

    // request types
    localparam logic [1:0] REQ_COEFF = 2'd0;
    localparam logic [1:0] REQ_RHS   = 2'd1;
    localparam logic [1:0] REQ_GUESS = 2'd2;
    localparam logic [1:0] REQ_START = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXSW  = 3'd4;

    // vector store regions
    localparam logic [1:0] REG_RHS  = 2'd0;
    localparam logic [1:0] REG_EST  = 2'd1;
    localparam logic [1:0] REG_NEXT = 2'd2;

    localparam logic [14:0] OMEGA_ONE = 15'd16384;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] load_value;
    } ils_in_t;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution_value;
        logic               last_element;
        logic               converged;
        logic [6:0]         sweeps;
    } ils_out_t;

    typedef struct packed {
        logic                we;
        logic [COEFF_AW-1:0] addr;
        logic [31:0]         data;
    } ils_coeff_wr_t;

    typedef struct packed {
        logic              we;
        logic [VEC_AW-1:0] addr;
        logic [31:0]       data;
    } ils_vec_wr_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } ils_div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } ils_div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TOL,
        ST_CHECK,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_DOT_RD,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_DIAG_RD,
        ST_DIAG_LD,
        ST_DIV_WAIT,
        ST_SOR_A,
        ST_SOR_B,
        ST_SOR_SUM,
        ST_WRITE,
        ST_UPD_RD_NEW,
        ST_UPD_RD_OLD,
        ST_UPD_SQ,
        ST_UPD_ACC,
        ST_CONV,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } ils_state_t;

endpackage

// ===== rtl/iterative_linear_solver.sv =====
// Iterative linear solver top level: sequencer, arithmetic and result port.
// Load words take one cycle each. A start word holds the block for the whole solve.
// Per row of a sweep: fetch the rhs, the dot product (read, multiply, saturating subtract),
// the diagonal read and bit-serial divide, relaxation (Gauss-Seidel only) and a write;
// each sweep also adds the change norm. N result words then follow, one at a time, each
// waiting out any output stall.
// Reset clears the sequencer and loads register defaults; memory contents stay undefined.
module iterative_linear_solver (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ils_pkg::ils_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ils_pkg::ils_out_t                  out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ils_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data
);

    ils_pkg::ils_state_t state_reg, state_next;

    logic [4:0]  size_reg;
    logic        method_reg;
    logic [14:0] relax_reg;
    logic [30:0] tol_reg;
    logic [6:0]  maxsw_reg;

    logic [ils_pkg::ROW_W-1:0] i_reg, j_reg, last_reg;
    logic [6:0]  sweep_reg;
    logic        conv_reg;
    logic        out_valid_reg;

    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [61:0]        tol2_reg;
    logic [63:0]        chg_reg;
    logic signed [31:0] xold_reg;
    logic signed [31:0] xnew_reg;
    logic signed [31:0] gs_reg;
    logic signed [31:0] v_reg;
    logic signed [48:0] sor_a_reg;
    logic signed [47:0] sor_b_reg;
    logic [63:0]        sq_reg;
    ils_pkg::ils_out_t  out_reg;

    ils_pkg::ils_coeff_wr_t      coeff_wr;
    ils_pkg::ils_vec_wr_t        vec_wr;
    logic [ils_pkg::COEFF_AW-1:0] coeff_rd_addr;
    logic [ils_pkg::VEC_AW-1:0]   vec_rd_addr;
    logic [31:0]                  coeff_rd_data;
    logic [31:0]                  vec_rd_data;
    ils_pkg::ils_div_req_t       div_req;
    ils_pkg::ils_div_rsp_t       div_rsp;

    logic        in_acc;
    logic        out_acc;
    logic [4:0]  n_act;
    logic [1:0]  xj_region;
    logic        j_is_last;
    logic        i_is_last;

    logic signed [64:0] sub_wide;
    logic signed [63:0] sub_sat;
    logic signed [16:0] w_comp;
    logic signed [50:0] sor_t;
    logic signed [36:0] sor_sh;
    logic signed [31:0] sor_v;
    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [64:0]        chg_sum;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid_reg && !out_stall;
    assign in_stall  = state_reg != ils_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign n_act     = (size_reg == 5'd0) ? 5'd1 :
                       ((size_reg > 5'(ils_pkg::MAX_SIZE)) ? 5'(ils_pkg::MAX_SIZE) : size_reg);
    assign j_is_last = j_reg == last_reg;
    assign i_is_last = i_reg == last_reg;
    assign xj_region = (method_reg && (j_reg < i_reg)) ? ils_pkg::REG_NEXT : ils_pkg::REG_EST;

    // saturating acc - product
    assign sub_wide = {acc_reg[63], acc_reg} - {prod_reg[63], prod_reg};
    assign sub_sat  = (sub_wide[64] != sub_wide[63]) ?
                      (sub_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sub_wide[63:0];

    // relaxation: floor((1-w)*xold + w*gs + 0.5) in Q14, saturated
    assign w_comp = 17'sd16384 - $signed({2'b00, relax_reg});
    assign sor_t  = 51'(sor_a_reg) + 51'(sor_b_reg) + 51'sd8192;
    assign sor_sh = 37'(sor_t >>> 14);
    assign sor_v  = (sor_sh > 37'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                    ((sor_sh < -37'sh80000000) ? 32'sh80000000 : sor_sh[31:0]);

    // old estimate taken straight from the memory output
    assign diff    = {xnew_reg[31], xnew_reg} - {vec_rd_data[31], vec_rd_data};
    assign mag     = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
    assign chg_sum = {1'b0, chg_reg} + {1'b0, sq_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ils_pkg::ST_IDLE:
                if (in_acc && in_data.req_type == ils_pkg::REQ_START)
                    state_next = ils_pkg::ST_TOL;
            ils_pkg::ST_TOL:
                state_next = ils_pkg::ST_CHECK;
            ils_pkg::ST_CHECK:
                state_next = (sweep_reg < maxsw_reg) ? ils_pkg::ST_ROW_RD : ils_pkg::ST_OUT_RD;
            ils_pkg::ST_ROW_RD:
                state_next = ils_pkg::ST_ROW_LD;
            ils_pkg::ST_ROW_LD:
                state_next = ils_pkg::ST_DOT_RD;
            ils_pkg::ST_DOT_RD:
                if (j_reg == i_reg)
                    state_next = j_is_last ? ils_pkg::ST_DIAG_RD : ils_pkg::ST_DOT_RD;
                else
                    state_next = ils_pkg::ST_DOT_MUL;
            ils_pkg::ST_DOT_MUL:
                state_next = ils_pkg::ST_DOT_ACC;
            ils_pkg::ST_DOT_ACC:
                state_next = j_is_last ? ils_pkg::ST_DIAG_RD : ils_pkg::ST_DOT_RD;
            ils_pkg::ST_DIAG_RD:
                state_next = ils_pkg::ST_DIAG_LD;
            ils_pkg::ST_DIAG_LD:
                state_next = ils_pkg::ST_DIV_WAIT;
            ils_pkg::ST_DIV_WAIT:
                if (div_rsp.done)
                    state_next = method_reg ? ils_pkg::ST_SOR_A : ils_pkg::ST_WRITE;
            ils_pkg::ST_SOR_A:
                state_next = ils_pkg::ST_SOR_B;
            ils_pkg::ST_SOR_B:
                state_next = ils_pkg::ST_SOR_SUM;
            ils_pkg::ST_SOR_SUM:
                state_next = ils_pkg::ST_WRITE;
            ils_pkg::ST_WRITE:
                state_next = i_is_last ? ils_pkg::ST_UPD_RD_NEW : ils_pkg::ST_ROW_RD;
            ils_pkg::ST_UPD_RD_NEW:
                state_next = ils_pkg::ST_UPD_RD_OLD;
            ils_pkg::ST_UPD_RD_OLD:
                state_next = ils_pkg::ST_UPD_SQ;
            ils_pkg::ST_UPD_SQ:
                state_next = ils_pkg::ST_UPD_ACC;
            ils_pkg::ST_UPD_ACC:
                state_next = i_is_last ? ils_pkg::ST_CONV : ils_pkg::ST_UPD_RD_NEW;
            ils_pkg::ST_CONV:
                state_next = (chg_reg < {2'b00, tol2_reg}) ? ils_pkg::ST_OUT_RD : ils_pkg::ST_CHECK;
            ils_pkg::ST_OUT_RD:
                state_next = ils_pkg::ST_OUT_LD;
            ils_pkg::ST_OUT_LD:
                state_next = ils_pkg::ST_OUT_WAIT;
            ils_pkg::ST_OUT_WAIT:
                if (out_acc)
                    state_next = i_is_last ? ils_pkg::ST_IDLE : ils_pkg::ST_OUT_RD;
            default:
                state_next = ils_pkg::ST_IDLE;
        endcase
    end

    // memory and divider strobes
    always_comb
    begin
        coeff_wr      = '0;
        vec_wr        = '0;
        coeff_rd_addr = {i_reg, j_reg};
        vec_rd_addr   = {ils_pkg::REG_EST, i_reg};
        div_req.start = 1'b0;
        div_req.num   = acc_reg;
        div_req.den   = $signed(coeff_rd_data);
        case (state_reg)
            ils_pkg::ST_IDLE:
            begin
                coeff_wr.we   = in_acc && in_data.req_type == ils_pkg::REQ_COEFF;
                coeff_wr.addr = {in_data.row, in_data.col};
                coeff_wr.data = in_data.load_value;
                vec_wr.we     = in_acc && (in_data.req_type == ils_pkg::REQ_RHS ||
                                           in_data.req_type == ils_pkg::REQ_GUESS);
                vec_wr.addr   = {(in_data.req_type == ils_pkg::REQ_RHS) ?
                                 ils_pkg::REG_RHS : ils_pkg::REG_EST, in_data.row};
                vec_wr.data   = in_data.load_value;
            end
            ils_pkg::ST_ROW_RD:
                vec_rd_addr = {ils_pkg::REG_RHS, i_reg};
            ils_pkg::ST_DOT_RD:
            begin
                coeff_rd_addr = {i_reg, j_reg};
                vec_rd_addr   = {xj_region, j_reg};
            end
            ils_pkg::ST_DIAG_RD:
            begin
                coeff_rd_addr = {i_reg, i_reg};
                vec_rd_addr   = {ils_pkg::REG_EST, i_reg};
            end
            ils_pkg::ST_DIAG_LD:
                div_req.start = 1'b1;
            ils_pkg::ST_WRITE:
            begin
                vec_wr.we   = 1'b1;
                vec_wr.addr = {ils_pkg::REG_NEXT, i_reg};
                vec_wr.data = v_reg;
            end
            ils_pkg::ST_UPD_RD_NEW:
                vec_rd_addr = {ils_pkg::REG_NEXT, i_reg};
            ils_pkg::ST_UPD_RD_OLD:
                vec_rd_addr = {ils_pkg::REG_EST, i_reg};
            ils_pkg::ST_UPD_ACC:
            begin
                vec_wr.we   = 1'b1;
                vec_wr.addr = {ils_pkg::REG_EST, i_reg};
                vec_wr.data = xnew_reg;
            end
            ils_pkg::ST_OUT_RD:
                vec_rd_addr = {ils_pkg::REG_EST, i_reg};
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ils_pkg::ST_IDLE;
            size_reg      <= 5'd16;
            method_reg    <= 1'b0;
            relax_reg     <= ils_pkg::OMEGA_ONE;
            tol_reg       <= 31'd1;
            maxsw_reg     <= 7'd100;
            i_reg         <= '0;
            j_reg         <= '0;
            last_reg      <= '0;
            sweep_reg     <= '0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ils_pkg::CFG_SIZE:   size_reg   <= cfg_data[4:0];
                    ils_pkg::CFG_METHOD: method_reg <= cfg_data[0];
                    ils_pkg::CFG_RELAX:  relax_reg  <= cfg_data[14:0];
                    ils_pkg::CFG_TOL:    tol_reg    <= cfg_data[30:0];
                    ils_pkg::CFG_MAXSW:  maxsw_reg  <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                ils_pkg::ST_TOL:
                begin
                    last_reg  <= ils_pkg::ROW_W'(n_act - 5'd1);
                    sweep_reg <= 7'd1;
                    conv_reg  <= 1'b0;
                    i_reg     <= '0;
                end
                ils_pkg::ST_CHECK:
                    i_reg <= '0;
                ils_pkg::ST_ROW_LD:
                    j_reg <= '0;
                ils_pkg::ST_DOT_RD:
                    if (j_reg == i_reg && !j_is_last)
                        j_reg <= j_reg + 1'b1;
                ils_pkg::ST_DOT_ACC:
                    if (!j_is_last)
                        j_reg <= j_reg + 1'b1;
                ils_pkg::ST_WRITE:
                    i_reg <= i_is_last ? '0 : i_reg + 1'b1;
                ils_pkg::ST_UPD_ACC:
                    if (!i_is_last)
                        i_reg <= i_reg + 1'b1;
                ils_pkg::ST_CONV:
                begin
                    i_reg <= '0;
                    if (chg_reg < {2'b00, tol2_reg})
                        conv_reg <= 1'b1;
                    else
                        sweep_reg <= sweep_reg + 7'd1;
                end
                ils_pkg::ST_OUT_LD:
                    out_valid_reg <= 1'b1;
                ils_pkg::ST_OUT_WAIT:
                    if (out_acc)
                    begin
                        out_valid_reg <= 1'b0;
                        i_reg         <= i_reg + 1'b1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ils_pkg::ST_TOL:
                tol2_reg <= tol_reg * tol_reg;
            ils_pkg::ST_ROW_LD:
                acc_reg <= {{16{vec_rd_data[31]}}, vec_rd_data, 16'h0000};
            ils_pkg::ST_DOT_MUL:
                prod_reg <= $signed(coeff_rd_data) * $signed(vec_rd_data);
            ils_pkg::ST_DOT_ACC:
                acc_reg <= sub_sat;
            ils_pkg::ST_DIAG_LD:
                xold_reg <= $signed(vec_rd_data);
            ils_pkg::ST_DIV_WAIT:
            begin
                gs_reg <= div_rsp.quot;
                v_reg  <= div_rsp.quot;
            end
            ils_pkg::ST_SOR_A:
                sor_a_reg <= w_comp * xold_reg;
            ils_pkg::ST_SOR_B:
                sor_b_reg <= $signed({1'b0, relax_reg}) * gs_reg;
            ils_pkg::ST_SOR_SUM:
                v_reg <= sor_v;
            ils_pkg::ST_CHECK:
                chg_reg <= '0;
            ils_pkg::ST_UPD_RD_OLD:
                xnew_reg <= $signed(vec_rd_data);
            ils_pkg::ST_UPD_ACC:
                chg_reg <= chg_sum[64] ? {64{1'b1}} : chg_sum[63:0];
            ils_pkg::ST_OUT_LD:
            begin
                out_reg.index          <= i_reg;
                out_reg.solution_value <= $signed(vec_rd_data);
                out_reg.last_element   <= i_is_last;
                out_reg.converged      <= conv_reg;
                out_reg.sweeps         <= conv_reg ? sweep_reg : 7'd0;
            end
            default:
            begin
            end
        endcase
        // square of the change, registered in the cycle the old estimate arrives
        sq_reg <= mag * mag;
    end

    ils_store u_store (
        .clk           (clk),
        .coeff_wr      (coeff_wr),
        .coeff_rd_addr (coeff_rd_addr),
        .coeff_rd_data (coeff_rd_data),
        .vec_wr        (vec_wr),
        .vec_rd_addr   (vec_rd_addr),
        .vec_rd_data   (vec_rd_data)
    );

    ils_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

`ifndef SYNTHESIS
    a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ils_pkg::ST_OUT_WAIT))
        else $error("result word valid outside output phase");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ils_pkg::ST_DIV_WAIT))
        else $error("divider finished while sequencer not waiting");

    a_last_ends_solve: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_reg.last_element) |=> (state_reg == ils_pkg::ST_IDLE))
        else $error("solve did not end after last result word");

    a_failed_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.converged) |-> (out_reg.sweeps == 7'd0))
        else $error("failed solve reports nonzero sweep count");
`endif

endmodule

// ===== rtl/ils_store.sv =====
// Coefficient memory and vector memory (rhs, estimate, next estimate).
module ils_store (
    input  logic                             clk,
    input  ils_pkg::ils_coeff_wr_t           coeff_wr,
    input  logic [ils_pkg::COEFF_AW-1:0]     coeff_rd_addr,
    output logic [31:0]                      coeff_rd_data,
    input  ils_pkg::ils_vec_wr_t             vec_wr,
    input  logic [ils_pkg::VEC_AW-1:0]       vec_rd_addr,
    output logic [31:0]                      vec_rd_data
);

    logic [31:0] coeff_mem [ils_pkg::COEFF_DEPTH];
    logic [31:0] vec_mem   [ils_pkg::VEC_DEPTH];

    always_ff @(posedge clk)
    begin
        if (coeff_wr.we)
        begin
            coeff_mem[coeff_wr.addr] <= coeff_wr.data;
        end
        coeff_rd_data <= coeff_mem[coeff_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vec_wr.we)
        begin
            vec_mem[vec_wr.addr] <= vec_wr.data;
        end
        vec_rd_data <= vec_mem[vec_rd_addr];
    end

endmodule

// ===== rtl/ils_div.sv =====
// Radix-2 restoring divider: signed 64 / signed 32, truncating, saturated to 32 bits.
module ils_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ils_pkg::ils_div_req_t req,
    output ils_pkg::ils_div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [63:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic        neg_reg;
    logic        zero_reg;
    logic        rpos_reg;
    logic        rneg_reg;

    logic [63:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] rem_sh;
    logic        take;
    logic signed [31:0] q_sat;

    assign num_mag = req.num[63] ? (64'd0 - req.num) : req.num;
    assign den_mag = req.den[31] ? (32'd0 - req.den) : req.den;
    assign rem_sh  = {rem_reg, num_reg[63]};
    assign take    = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= num_mag;
            den_reg  <= den_mag;
            rem_reg  <= '0;
            quo_reg  <= '0;
            neg_reg  <= req.num[63] != req.den[31];
            zero_reg <= req.den == 32'sd0;
            rpos_reg <= !req.num[63] && (req.num != 64'sd0);
            rneg_reg <= req.num[63];
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], 1'b0};
            rem_reg <= take ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            quo_reg <= {quo_reg[62:0], take};
        end
    end

    always_comb
    begin
        if (zero_reg)
        begin
            q_sat = rpos_reg ? 32'sh7FFFFFFF : (rneg_reg ? 32'sh80000000 : 32'sd0);
        end
        else if (neg_reg)
        begin
            q_sat = (quo_reg > 64'h80000000) ? 32'sh80000000 : 32'(64'd0 - quo_reg);
        end
        else
        begin
            q_sat = (quo_reg > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : quo_reg[31:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_sat;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the iterative linear solver.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        ils_pkg::ils_in_t word;
        bit               hold;   // wait for all results before sending more
    } staged_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    ils_pkg::ils_in_t              in_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    ils_pkg::ils_out_t             out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ils_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data = '0;

    staged_t           word_queue[$];
    ils_pkg::ils_out_t solution_queue[$];
    logic     in_taken = 1'b0;
    int       accepted_words = 0;
    int       send_idle = 12;
    int       recv_idle = 82;
    int       errors = 0;
    int       solves = 0;
    int       results_seen = 0;
    int       converged_solves = 0;
    int       staged_words = 0;

    // solver state mirror
    longint      coef[ils_pkg::MAX_SIZE*ils_pkg::MAX_SIZE];
    longint      rhs_v[ils_pkg::MAX_SIZE];
    longint      est[ils_pkg::MAX_SIZE];
    longint      nxt[ils_pkg::MAX_SIZE];
    int unsigned cfg_n = 16, cfg_method = 0, cfg_omega = 16384, cfg_tol = 1, cfg_maxsw = 100;
    longint unsigned last_norm;

    // what the stimulus side has written so far
    bit a_wr[ils_pkg::MAX_SIZE*ils_pkg::MAX_SIZE];
    bit b_wr[ils_pkg::MAX_SIZE];
    bit x_wr[ils_pkg::MAX_SIZE];

    iterative_linear_solver i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint sub_sat(longint a, longint p);
        longint mn;
        longint mx;
        mn = 64'sh8000_0000_0000_0000;
        mx = 64'sh7FFF_FFFF_FFFF_FFFF;
        if (p > 0 && a < mn + p)
            return mn;
        if (p < 0 && a > mx + p)
            return mx;
        return a - p;
    endfunction

    function automatic longint div_sat(longint r, longint d);
        longint unsigned ur;
        longint unsigned ud;
        longint unsigned q;
        bit              neg;
        if (d == 0)
            return (r > 0) ? 64'sd2147483647 : ((r < 0) ? -64'sd2147483648 : 64'sd0);
        ur = (r < 0) ? -r : r;
        ud = (d < 0) ? -d : d;
        q = ur / ud;
        neg = (r < 0) != (d < 0);
        if (neg)
            return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic void relax_sweep(int unsigned n);
        longint          acc;
        longint          gs;
        longint          xj;
        longint          t;
        longint          w;
        longint          d;
        longint unsigned m;
        longint unsigned sq;
        longint unsigned norm;
        norm = 0;
        w = cfg_omega;
        for (int i = 0; i < n; i++)
        begin
            acc = rhs_v[i] * 65536;
            for (int j = 0; j < n; j++)
            begin
                if (j != i)
                begin
                    xj = (cfg_method != 0 && j < i) ? nxt[j] : est[j];
                    acc = sub_sat(acc, coef[i*ils_pkg::MAX_SIZE+j] * xj);
                end
            end
            gs = div_sat(acc, coef[i*ils_pkg::MAX_SIZE+i]);
            if (cfg_method != 0)
            begin
                t = (16384 - w) * est[i] + w * gs + 8192;
                nxt[i] = sat32(t >>> 14);
            end
            else
                nxt[i] = gs;
        end
        for (int i = 0; i < n; i++)
        begin
            d = nxt[i] - est[i];
            m = (d < 0) ? -d : d;
            sq = m * m;
            norm = (norm > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : norm + sq;
            est[i] = nxt[i];
        end
        last_norm = norm;
    endfunction

    function automatic void solve_system();
        int unsigned       n;
        int unsigned       cnt;
        bit                conv;
        longint unsigned   tol2;
        ils_pkg::ils_out_t r;
        n = (cfg_n == 0) ? 1 : ((cfg_n > ils_pkg::MAX_SIZE) ? ils_pkg::MAX_SIZE : cfg_n);
        tol2 = longint'(cfg_tol) * longint'(cfg_tol);
        conv = 1'b0;
        cnt = 1;
        while (cnt < cfg_maxsw)
        begin
            relax_sweep(n);
            if (last_norm < tol2)
            begin
                conv = 1'b1;
                break;
            end
            cnt = (cnt + 1) & 7'h7F;
        end
        for (int i = 0; i < n; i++)
        begin
            r.index = 4'(i);
            r.solution_value = est[i][31:0];
            r.last_element = (i == n - 1);
            r.converged = conv;
            r.sweeps = conv ? cnt[6:0] : 7'd0;
            solution_queue.push_back(r);
        end
        solves++;
        if (conv)
            converged_solves++;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h, wanted %0h", what, got, want);
        errors++;
    endtask

    // input word acceptance and result checking
    always @(posedge clk)
    begin
        ils_pkg::ils_out_t want;
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            accepted_words++;
            case (in_data.req_type)
                ils_pkg::REQ_COEFF:
                    coef[in_data.row*ils_pkg::MAX_SIZE+in_data.col] =
                        longint'(in_data.load_value);
                ils_pkg::REQ_RHS:   rhs_v[in_data.row] = longint'(in_data.load_value);
                ils_pkg::REQ_GUESS: est[in_data.row] = longint'(in_data.load_value);
                default:            solve_system();
            endcase
        end
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (solution_queue.size() == 0)
                report("unexpected result word", out_data.solution_value, 32'h0);
            else
            begin
                want = solution_queue.pop_front();
                if (out_data.index !== want.index)
                    report("index", 32'(out_data.index), 32'(want.index));
                if (out_data.solution_value !== want.solution_value)
                    report("solution_value", out_data.solution_value, want.solution_value);
                if (out_data.last_element !== want.last_element)
                    report("last_element", 32'(out_data.last_element),
                           32'(want.last_element));
                if (out_data.converged !== want.converged)
                    report("converged", 32'(out_data.converged), 32'(want.converged));
                if (out_data.sweeps !== want.sweeps)
                    report("sweeps", 32'(out_data.sweeps), 32'(want.sweeps));
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        logic    v;
        staged_t s;
        if (accepted_words < 170)
        begin
            send_idle = 12;
            recv_idle = 82;
        end
        else if (accepted_words < 340)
        begin
            send_idle = 82;
            recv_idle = 12;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        out_stall <= ($urandom_range(99) < recv_idle);
        if (!in_valid || in_taken)
        begin
            v = 1'b0;
            if (word_queue.size() > 0)
            begin
                if (word_queue[0].hold)
                begin
                    if (solution_queue.size() == 0)
                        s = word_queue.pop_front();
                end
                else if ($urandom_range(99) >= send_idle)
                begin
                    s = word_queue.pop_front();
                    in_data <= s.word;
                    v = 1'b1;
                end
            end
            in_valid <= v;
        end
    end

    function automatic void stage_word(logic [1:0] req, int row, int col, int val);
        staged_t s;
        s.hold = 1'b0;
        s.word.req_type = req;
        s.word.row = 4'(row);
        s.word.col = 4'(col);
        s.word.load_value = val;
        word_queue.push_back(s);
        staged_words++;
        if (req == ils_pkg::REQ_COEFF)
            a_wr[row*ils_pkg::MAX_SIZE+col] = 1'b1;
        else if (req == ils_pkg::REQ_RHS)
            b_wr[row] = 1'b1;
        else if (req == ils_pkg::REQ_GUESS)
            x_wr[row] = 1'b1;
    endfunction

    function automatic void stage_hold();
        staged_t s;
        s.hold = 1'b1;
        s.word = '0;
        word_queue.push_back(s);
    endfunction

    function automatic int small_val(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // load a full system of size n (dominant diagonal unless broken) or reuse the last, then start
    function automatic void stage_system(int n, bit broken);
        int v;
        bit all_written;
        all_written = 1'b1;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                all_written &= a_wr[i*ils_pkg::MAX_SIZE+j];
        for (int i = 0; i < n; i++)
            all_written &= b_wr[i] & x_wr[i];
        // repeated start: continue from current estimate
        if (!all_written || $urandom_range(99) >= 20)
        begin
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    if (broken)
                        v = $urandom;
                    else if (i == j)
                        v = (2 * n + $urandom_range(4)) * 65536 * ($urandom_range(1) ? 1 : -1);
                    else
                        v = small_val(65536);
                    stage_word(ils_pkg::REQ_COEFF, i, j, v);
                end
                stage_word(ils_pkg::REQ_RHS, i, 0, broken ? $urandom : small_val(1 << 20));
                stage_word(ils_pkg::REQ_GUESS, i, 0, broken ? $urandom : small_val(1 << 18));
            end
        end
        // noise: stray loads anywhere, full-range values
        if ($urandom_range(99) < 25)
        begin
            for (int k = 0; k < 3; k++)
                stage_word(2'($urandom_range(2)), $urandom_range(15), $urandom_range(15),
                           $urandom);
        end
        stage_word(ils_pkg::REQ_START, $urandom_range(15), $urandom_range(15), $urandom);
        if ($urandom_range(99) < 30)
            stage_hold();
    endfunction

    task automatic write_reg(input logic [ils_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ils_pkg::CFG_SIZE:   cfg_n = val & 32'h1F;
            ils_pkg::CFG_METHOD: cfg_method = val & 32'h1;
            ils_pkg::CFG_RELAX:  cfg_omega = val & 32'h7FFF;
            ils_pkg::CFG_TOL:    cfg_tol = val & 32'h7FFF_FFFF;
            default:             cfg_maxsw = val & 32'h7F;
        endcase
    endtask

    task automatic wait_idle();
        while (word_queue.size() > 0 || in_valid || solution_queue.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(int n, int meth, int omega, int tol, int maxsw);
        wait_idle();
        write_reg(ils_pkg::CFG_SIZE, n);
        write_reg(ils_pkg::CFG_METHOD, meth);
        write_reg(ils_pkg::CFG_RELAX, omega);
        write_reg(ils_pkg::CFG_TOL, tol);
        write_reg(ils_pkg::CFG_MAXSW, maxsw);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int n_tab[6]      = '{3, 4, 2, 5, 16, 3};
        int meth_tab[6]   = '{1, 1, 1, 0, 0, 1};
        int omega_tab[6]  = '{16384, 32767, 0, 9000, 16384, 20000};
        int tol_tab[6]    = '{64, 2147483647, 16, 1000, 100, 1};
        int maxsw_tab[6]  = '{40, 127, 127, 30, 2, 60};
        int target_tab[6] = '{80, 130, 165, 195, 0, 500};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: single unknown, extremes and zero diagonal
        set_config(1, 0, 16384, 0, 2);
        stage_word(ils_pkg::REQ_COEFF, 0, 0, 0);
        stage_word(ils_pkg::REQ_RHS, 0, 0, 32'h7FFF_FFFF);
        stage_word(ils_pkg::REQ_GUESS, 0, 0, 32'h8000_0000);
        stage_word(ils_pkg::REQ_START, 0, 0, 0);
        stage_word(ils_pkg::REQ_RHS, 0, 0, 32'h8000_0000);
        stage_word(ils_pkg::REQ_START, 15, 15, 32'hFFFF_FFFF);
        stage_word(ils_pkg::REQ_RHS, 0, 0, 0);
        stage_word(ils_pkg::REQ_GUESS, 0, 0, 0);
        stage_word(ils_pkg::REQ_START, 0, 0, 0);     // zero residual over zero diagonal
        stage_word(ils_pkg::REQ_COEFF, 0, 0, 32'h8000_0000);
        stage_word(ils_pkg::REQ_RHS, 0, 0, 32'h7FFF_FFFF);
        stage_word(ils_pkg::REQ_START, 0, 0, 0);
        stage_word(ils_pkg::REQ_COEFF, 0, 0, 65536);
        stage_word(ils_pkg::REQ_RHS, 0, 0, -1);
        stage_word(ils_pkg::REQ_GUESS, 0, 0, 32'h7FFF_FFFF);
        stage_word(ils_pkg::REQ_START, 0, 0, 0);
        stage_word(ils_pkg::REQ_COEFF, 15, 15, 32'h7FFF_FFFF);
        stage_word(ils_pkg::REQ_COEFF, 0, 15, 1);
        stage_word(ils_pkg::REQ_COEFF, 0, 0, 1);
        stage_word(ils_pkg::REQ_RHS, 0, 0, 32'h7FFF_FFFF);
        stage_word(ils_pkg::REQ_START, 0, 0, 0);
        stage_hold();

        for (int p = 0; p < 6; p++)
        begin
            set_config(n_tab[p], meth_tab[p], omega_tab[p], tol_tab[p], maxsw_tab[p]);
            do
                stage_system(n_tab[p], (n_tab[p] < 16) && ($urandom_range(99) < 25));
            while (staged_words < target_tab[p]);
        end
        wait_idle();
        repeat (300) @(posedge clk);
        $display("Ran %0d solves (%0d converged) over %0d input words, checked %0d results.",
                 solves, converged_solves, accepted_words, results_seen);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== iterative_linear_solver.f =====
rtl/ils_pkg.sv
rtl/ils_store.sv
rtl/ils_div.sv
rtl/iterative_linear_solver.sv
tb/sv/testbench.sv
